// ===== rtl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants of the double-ended queue
// Ring geometry, command and status codes, and the memory request bundle
// passed between the control logic and the entry storage.
// ----------------------------------------------------------------------------
package deq_pkg;

	// Ring geometry.
	localparam int DEPTH   = 16;
	localparam int PTR_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int SUM_W   = CNT_W + 1;

	// Fixed field widths of the channels.
	localparam int CMD_W   = 3;
	localparam int DATA_W  = 32;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;

	typedef logic [CMD_W-1:0]         cmd_t;
	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [STAT_W-1:0]        status_t;
	typedef logic [COUNT_W-1:0]       count_t;
	typedef logic [PTR_W-1:0]         ptr_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic [SUM_W-1:0]         sum_t;

	// Command codes.
	localparam cmd_t CMD_PUSH_BACK  = 3'd0;
	localparam cmd_t CMD_PUSH_FRONT = 3'd1;
	localparam cmd_t CMD_POP_BACK   = 3'd2;
	localparam cmd_t CMD_POP_FRONT  = 3'd3;
	localparam cmd_t CMD_READ_BACK  = 3'd4;
	localparam cmd_t CMD_READ_FRONT = 3'd5;

	// Status codes.
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	// One access to the entry storage.
	typedef struct packed {
		logic  we;
		logic  re;
		ptr_t  addr;
		data_t wdata;
	} ram_req_t;

	// Fold a position below twice the depth back into the ring.
	function automatic ptr_t wrap_pos(input sum_t p);
		sum_t r;
		r = p;
		if (p >= SUM_W'(DEPTH)) begin
			r = p - SUM_W'(DEPTH);
		end
		return PTR_W'(r);
	endfunction

endpackage

// ===== rtl/deq_if.sv =====
// ----------------------------------------------------------------------------
// deq_if: valid/ready channels of the double-ended queue
// The command channel carries a command and a value; the result channel
// carries the read value, the status, the count and the empty flag.
// ----------------------------------------------------------------------------
interface deq_req_if;
	logic          valid;
	logic          ready;
	deq_pkg::cmd_t  cmd;
	deq_pkg::data_t value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface deq_rsp_if;
	logic             valid;
	logic             ready;
	deq_pkg::data_t   read_value;
	deq_pkg::status_t status;
	deq_pkg::count_t  count;
	logic             empty_res;

	modport source (output valid, output read_value, output status, output count,
		output empty_res, input ready);
	modport sink   (input valid, input read_value, input status, input count,
		input empty_res, output ready);
endinterface

// ===== rtl/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram: entry storage of the double-ended queue
// Single-port synchronous memory with a registered read. Entries
// hold no reset value; only written positions are ever read.
// ----------------------------------------------------------------------------
module deq_ram (
	input  logic              clk,
	input  deq_pkg::ram_req_t req,
	output deq_pkg::data_t    rdata
);
	import deq_pkg::*;

	data_t mem [DEPTH];
	data_t rdata_q;

	// Write on a push, registered read on a read command.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// deq_ctrl: pointer, count and result control of the double-ended queue
// Decodes each command beat, updates head and count, drives the memory
// access and holds the result beat until the sink takes it.
// ----------------------------------------------------------------------------
module deq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	deq_req_if.sink           req,
	deq_rsp_if.source         rsp,
	output deq_pkg::ram_req_t ram_req,
	input  deq_pkg::data_t    ram_rdata
);
	import deq_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_READ = 1'b1;

	logic    state_q;
	ptr_t    head_q;
	cnt_t    count_q;

	logic    rsp_valid_q;
	data_t   rd_q;
	status_t status_q;
	cnt_t    cnt_out_q;

	logic    accept;
	logic    full;
	logic    empty;
	sum_t    sum;
	ptr_t    tail_pos;
	ptr_t    back_pos;
	ptr_t    head_dec;
	ptr_t    head_inc;

	ptr_t    head_n;
	cnt_t    count_n;
	status_t status_n;
	logic    we;
	logic    re;
	ptr_t    addr;

	// A new beat enters only when idle and the result register is free or draining.
	assign req.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	// Ring positions around the current head and count.
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign sum      = SUM_W'(head_q) + SUM_W'(count_q);
	assign tail_pos = wrap_pos(sum);
	assign back_pos = wrap_pos(sum - SUM_W'(1));
	assign head_dec = (head_q == '0) ? PTR_W'(DEPTH - 1) : head_q - PTR_W'(1);
	assign head_inc = wrap_pos(SUM_W'(head_q) + SUM_W'(1));

	// Command decode.
	always_comb begin
		head_n   = head_q;
		count_n  = count_q;
		status_n = ST_OK;
		we       = 1'b0;
		re       = 1'b0;
		addr     = head_q;
		case (req.cmd)
			CMD_PUSH_BACK: begin
				if (full) begin
					status_n = ST_FULL;
				end else begin
					we      = 1'b1;
					addr    = tail_pos;
					count_n = count_q + CNT_W'(1);
				end
			end
			CMD_PUSH_FRONT: begin
				if (full) begin
					status_n = ST_FULL;
				end else begin
					we      = 1'b1;
					addr    = head_dec;
					head_n  = head_dec;
					count_n = count_q + CNT_W'(1);
				end
			end
			CMD_POP_BACK: begin
				if (empty) begin
					status_n = ST_EMPTY;
				end else begin
					count_n = count_q - CNT_W'(1);
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					status_n = ST_EMPTY;
				end else begin
					head_n  = head_inc;
					count_n = count_q - CNT_W'(1);
				end
			end
			CMD_READ_BACK: begin
				re   = !empty;
				addr = back_pos;
			end
			CMD_READ_FRONT: begin
				re   = !empty;
				addr = head_q;
			end
			default: begin
			end
		endcase
	end

	// Memory access goes out in the cycle of the command beat.
	always_comb begin
		ram_req.we    = accept && we;
		ram_req.re    = accept && re;
		ram_req.addr  = addr;
		ram_req.wdata = req.value;
	end

	// Control state: sequencer, head, count and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						head_q      <= head_n;
						count_q     <= count_n;
						rsp_valid_q <= !re;
						if (re) begin
							state_q <= S_READ;
						end
					end else if (rsp.ready) begin
						rsp_valid_q <= 1'b0;
					end
				end
				S_READ: begin
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result payload; the read value is taken from the registered memory output in the read state.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q      <= '0;
			status_q  <= status_n;
			cnt_out_q <= count_n;
		end else if (state_q == S_READ) begin
			rd_q <= ram_rdata;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = rd_q;
	assign rsp.status     = status_q;
	assign rsp.count      = COUNT_W'(cnt_out_q);
	assign rsp.empty_res  = (cnt_out_q == '0);

	// A memory read always completes into a result beat.
	a_read_completes: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.re |=> (state_q == S_READ) ##1 rsp_valid_q)
		else $error("read did not produce a result beat");

	// Memory is read only while the queue holds entries.
	a_read_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.re |-> (count_q != '0))
		else $error("memory read on empty queue");

	// A successful pop takes exactly one entry.
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.cmd == CMD_POP_BACK || req.cmd == CMD_POP_FRONT) && !empty
		|=> count_q == $past(count_q) - CNT_W'(1))
		else $error("pop did not decrement count");

	// A push on a full queue changes neither head nor count.
	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.cmd == CMD_PUSH_BACK || req.cmd == CMD_PUSH_FRONT) && full
		|=> $stable(count_q) && $stable(head_q))
		else $error("push on full queue changed state");

	// The count never exceeds the ring depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> count_q <= CNT_W'(DEPTH))
		else $error("count beyond depth");

endmodule

// ===== rtl/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue: ring-buffer double-ended queue of signed 32-bit values
// Push, pop and read at either end; every command beat yields one result beat.
//
//   Channel  Role   Beat contents
//   req      sink   cmd (3), value (32, signed)
//   rsp      source read_value (32, signed), status (2), count (5), empty_res (1)
//
// Push and pop commands, and reads of an empty queue, have their result
// registered at the edge that accepts the command. Read commands on a nonempty
// queue pass through the memory read register and the read state first.
// Reset clears head and count; the entry memory has no reset and needs none.
// A stalled result holds its register; a new command is taken in the cycle the
// held result drains.
// ----------------------------------------------------------------------------
module double_ended_queue (
	input  logic      clk,
	input  logic      arst_n,
	deq_req_if.sink   req,
	deq_rsp_if.source rsp
);
	import deq_pkg::*;

	ram_req_t ram_req;
	data_t    ram_rdata;

	// Pointer, count and result control.
	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	// Entry storage.
	deq_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

endmodule
